// ===== rtl/core/bba_pkg.sv =====
// bba_pkg: sizes, mark and status codes, controller/datapath interface types
// for the bitmap block allocator. No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int NUM_BLOCKS  = 1024;
    localparam int BLOCK_BYTES = 16;    // power of two
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int HEAP_BYTES  = NUM_BLOCKS * BLOCK_BYTES;

    localparam int ADDR_W   = $clog2(NUM_BLOCKS);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int REQ_W    = 2;
    localparam int SIZE_W   = 16;
    localparam int OFF_W    = 16;
    localparam int STATUS_W = 3;
    localparam int RES_W    = 14;
    localparam int CFG_W    = 11;
    localparam int SUM_W    = SIZE_W + 1;
    localparam int CMP_W    = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_INIT  = 2'd2;

    typedef enum logic [1:0] {
        MARK_FREE = 2'd0,
        MARK_HEAD = 2'd1,
        MARK_FILL = 2'd2,
        MARK_RSVD = 2'd3
    } mark_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_TOO_BIG  = 3'd1,
        ST_FULL     = 3'd2,
        ST_OUTSIDE  = 3'd3,
        ST_RESERVED = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_CLEAR_START,
        DP_CLEAR_STEP,
        DP_SPAN_INIT,
        DP_SPAN_STEP,
        DP_SLOT_READ,
        DP_SLOT_SKIP,
        DP_SCAN_NEXT,
        DP_MARK_HEAD,
        DP_MARK_FILL,
        DP_FREE_READ,
        DP_FREE_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    latch;
        logic    load_out;
        status_t out_status;
        logic    out_alloc;
    } dp_cmd_t;

    typedef struct packed {
        logic  too_big;
        logic  outside;
        logic  span_done;
        logic  span_one;
        logic  slot_fits;
        logic  slot_last;
        logic  cur_last;
        mark_t mark;
    } dp_sts_t;

endpackage

// ===== rtl/core/bba_ram.sv =====
// bba_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bba_dp.sv =====
// bba_dp: allocator datapath - request latch, span/slot/cursor registers,
// mark RAM port control, result register. Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bba_pkg::dp_cmd_t                   cmd,
    output bba_pkg::dp_sts_t                   sts,
    input  logic [bba_pkg::SIZE_W-1:0]         size_bytes,
    input  logic [bba_pkg::OFF_W-1:0]          offset_bytes,
    input  logic                               cfg_we,
    input  logic [bba_pkg::CFG_W-1:0]          cfg_wdata,
    output logic                               ram_we,
    output logic [bba_pkg::ADDR_W-1:0]         ram_waddr,
    output logic [1:0]                         ram_wdata,
    output logic [bba_pkg::ADDR_W-1:0]         ram_raddr,
    input  logic [1:0]                         ram_rdata,
    output logic [bba_pkg::STATUS_W-1:0]       status,
    output logic [bba_pkg::RES_W-1:0]          result_offset
);

    logic [bba_pkg::CNT_W-1:0]  cur_reg;
    logic [bba_pkg::CNT_W-1:0]  slot_reg;
    logic [bba_pkg::CNT_W-1:0]  span_reg;
    logic [bba_pkg::SIZE_W-1:0] size_reg;
    logic [bba_pkg::OFF_W-1:0]  offset_reg;
    logic                       fill_rsvd_reg;
    logic [bba_pkg::CFG_W-1:0]  rsvd_cnt_reg;
    bba_pkg::status_t           status_reg;
    logic [bba_pkg::RES_W-1:0]  result_reg;

    logic [bba_pkg::CNT_W-1:0]  cur_plus;
    logic [bba_pkg::SUM_W-1:0]  blocks;
    logic [bba_pkg::ADDR_W-1:0] blk;
    logic [bba_pkg::CNT_W:0]    slot_end;
    bba_pkg::mark_t             clr_mark;

    assign cur_plus = cur_reg + bba_pkg::CNT_W'(1);
    assign blocks   = (bba_pkg::SUM_W'(size_reg) + bba_pkg::SUM_W'(bba_pkg::BLOCK_BYTES - 1))
                      >> bba_pkg::BLOCK_SHIFT;
    assign blk      = bba_pkg::ADDR_W'(offset_reg >> bba_pkg::BLOCK_SHIFT);
    assign slot_end = (bba_pkg::CNT_W+1)'(slot_reg) + (bba_pkg::CNT_W+1)'(span_reg);
    assign clr_mark = (fill_rsvd_reg &&
                       (bba_pkg::CMP_W'(cur_reg) < bba_pkg::CMP_W'(rsvd_cnt_reg)))
                      ? bba_pkg::MARK_RSVD : bba_pkg::MARK_FREE;

    always_comb
    begin
        sts.too_big   = 32'(size_reg) > 32'(bba_pkg::HEAP_BYTES);
        sts.outside   = 32'(offset_reg) >= 32'(bba_pkg::HEAP_BYTES);
        sts.span_done = bba_pkg::SUM_W'(span_reg) >= blocks;
        sts.span_one  = span_reg == bba_pkg::CNT_W'(1);
        sts.slot_fits = slot_end <= (bba_pkg::CNT_W+1)'(bba_pkg::NUM_BLOCKS);
        sts.slot_last = cur_reg == bba_pkg::CNT_W'(slot_end - (bba_pkg::CNT_W+1)'(1));
        sts.cur_last  = cur_reg == bba_pkg::CNT_W'(bba_pkg::NUM_BLOCKS - 1);
        sts.mark      = bba_pkg::mark_t'(ram_rdata);
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_reg[bba_pkg::ADDR_W-1:0];
        ram_wdata = bba_pkg::MARK_FREE;
        ram_raddr = cur_plus[bba_pkg::ADDR_W-1:0];
        case (cmd.op)
            bba_pkg::DP_CLEAR_STEP:
            begin
                ram_we    = 1'b1;
                ram_wdata = clr_mark;
            end
            bba_pkg::DP_MARK_HEAD:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_reg[bba_pkg::ADDR_W-1:0];
                ram_wdata = bba_pkg::MARK_HEAD;
            end
            bba_pkg::DP_MARK_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = bba_pkg::MARK_FILL;
            end
            bba_pkg::DP_FREE_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = bba_pkg::MARK_FREE;
            end
            bba_pkg::DP_SLOT_READ:
            begin
                ram_raddr = slot_reg[bba_pkg::ADDR_W-1:0];
            end
            bba_pkg::DP_FREE_READ:
            begin
                ram_raddr = blk;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            fill_rsvd_reg <= 1'b0;
            rsvd_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                rsvd_cnt_reg <= cfg_wdata;
            end
            case (cmd.op)
                bba_pkg::DP_CLEAR_START:
                begin
                    cur_reg       <= '0;
                    fill_rsvd_reg <= 1'b1;
                end
                bba_pkg::DP_CLEAR_STEP,
                bba_pkg::DP_SCAN_NEXT,
                bba_pkg::DP_MARK_FILL,
                bba_pkg::DP_FREE_CLEAR:
                begin
                    cur_reg <= cur_plus;
                end
                bba_pkg::DP_SLOT_READ:
                begin
                    cur_reg <= slot_reg;
                end
                bba_pkg::DP_MARK_HEAD:
                begin
                    cur_reg <= slot_reg + bba_pkg::CNT_W'(1);
                end
                bba_pkg::DP_FREE_READ:
                begin
                    cur_reg <= bba_pkg::CNT_W'(blk);
                end
                default:
                begin
                    cur_reg <= cur_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            size_reg   <= size_bytes;
            offset_reg <= offset_bytes;
        end
        case (cmd.op)
            bba_pkg::DP_SPAN_INIT:
            begin
                span_reg <= bba_pkg::CNT_W'(1);
                slot_reg <= '0;
            end
            bba_pkg::DP_SPAN_STEP:
            begin
                span_reg <= span_reg << 1;
            end
            bba_pkg::DP_SLOT_SKIP:
            begin
                slot_reg <= bba_pkg::CNT_W'(slot_end);
            end
            default:
            begin
                span_reg <= span_reg;
            end
        endcase
        if (cmd.load_out)
        begin
            status_reg <= cmd.out_status;
            result_reg <= cmd.out_alloc
                          ? bba_pkg::RES_W'(32'(slot_reg) << bba_pkg::BLOCK_SHIFT) : '0;
        end
    end

    assign status        = status_reg;
    assign result_offset = result_reg;

    a_head_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bba_pkg::DP_MARK_HEAD) |-> sts.slot_fits)
        else $error("head written for a slot past the heap end");

    a_span_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bba_pkg::DP_SLOT_READ) |-> $onehot(span_reg))
        else $error("span is not a power of two");

    a_no_free_rsvd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bba_pkg::DP_FREE_CLEAR) |-> (sts.mark != bba_pkg::MARK_RSVD))
        else $error("free walk cleared a reserved block");

endmodule

// ===== rtl/core/bba_ctrl.sv =====
// bba_ctrl: allocator control FSM - handshakes, request sequencing, datapath
// commands, result hand-off. Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bba_pkg::REQ_W-1:0]   req_type,
    output logic                        out_valid,
    input  logic                        out_ready,
    output bba_pkg::dp_cmd_t            cmd,
    input  bba_pkg::dp_sts_t            sts
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ACHK,
        S_SPAN,
        S_SLOT,
        S_SCAN,
        S_MARK,
        S_FCHK0,
        S_FCHK,
        S_FWALK,
        S_RESP
    } state_t;

    state_t           state_reg, state_next;
    logic             init_pass_reg, init_pass_next;
    bba_pkg::status_t resp_status_reg, resp_status_next;
    logic             resp_alloc_reg, resp_alloc_next;
    logic             out_valid_reg, out_valid_next;

    logic             fin;
    bba_pkg::status_t fin_status;
    logic             fin_alloc;

    always_comb
    begin
        cmd            = '{op: bba_pkg::DP_NONE, latch: 1'b0, load_out: 1'b0,
                           out_status: bba_pkg::ST_OK, out_alloc: 1'b0};
        state_next     = state_reg;
        init_pass_next = init_pass_reg;
        out_valid_next = out_valid_reg && !out_ready;
        fin            = 1'b0;
        fin_status     = bba_pkg::ST_OK;
        fin_alloc      = 1'b0;
        in_ready       = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = bba_pkg::DP_CLEAR_STEP;
                if (sts.cur_last)
                begin
                    if (init_pass_reg)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    case (req_type)
                        bba_pkg::REQ_ALLOC: state_next = S_ACHK;
                        bba_pkg::REQ_FREE:  state_next = S_FCHK0;
                        bba_pkg::REQ_INIT:
                        begin
                            cmd.op         = bba_pkg::DP_CLEAR_START;
                            init_pass_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        default:            fin = 1'b1;
                    endcase
                end
            end
            S_ACHK:
            begin
                if (sts.too_big)
                begin
                    fin        = 1'b1;
                    fin_status = bba_pkg::ST_TOO_BIG;
                end
                else
                begin
                    cmd.op     = bba_pkg::DP_SPAN_INIT;
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                if (sts.span_done)
                begin
                    state_next = S_SLOT;
                end
                else
                begin
                    cmd.op = bba_pkg::DP_SPAN_STEP;
                end
            end
            S_SLOT:
            begin
                if (!sts.slot_fits)
                begin
                    fin        = 1'b1;
                    fin_status = bba_pkg::ST_FULL;
                end
                else
                begin
                    cmd.op     = bba_pkg::DP_SLOT_READ;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.mark != bba_pkg::MARK_FREE)
                begin
                    cmd.op     = bba_pkg::DP_SLOT_SKIP;
                    state_next = S_SLOT;
                end
                else if (sts.slot_last)
                begin
                    cmd.op = bba_pkg::DP_MARK_HEAD;
                    if (sts.span_one)
                    begin
                        fin       = 1'b1;
                        fin_alloc = 1'b1;
                    end
                    else
                    begin
                        state_next = S_MARK;
                    end
                end
                else
                begin
                    cmd.op = bba_pkg::DP_SCAN_NEXT;
                end
            end
            S_MARK:
            begin
                cmd.op = bba_pkg::DP_MARK_FILL;
                if (sts.slot_last)
                begin
                    fin       = 1'b1;
                    fin_alloc = 1'b1;
                end
            end
            S_FCHK0:
            begin
                if (sts.outside)
                begin
                    fin        = 1'b1;
                    fin_status = bba_pkg::ST_OUTSIDE;
                end
                else
                begin
                    cmd.op     = bba_pkg::DP_FREE_READ;
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (sts.mark == bba_pkg::MARK_RSVD)
                begin
                    fin        = 1'b1;
                    fin_status = bba_pkg::ST_RESERVED;
                end
                else
                begin
                    cmd.op = bba_pkg::DP_FREE_CLEAR;
                    if (sts.cur_last)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FWALK;
                    end
                end
            end
            S_FWALK:
            begin
                if (sts.mark == bba_pkg::MARK_FILL)
                begin
                    cmd.op = bba_pkg::DP_FREE_CLEAR;
                    fin    = sts.cur_last;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_status = resp_status_reg;
                    cmd.out_alloc  = resp_alloc_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        resp_status_next = resp_status_reg;
        resp_alloc_next  = resp_alloc_reg;
        if (fin)
        begin
            state_next       = S_RESP;
            resp_status_next = fin_status;
            resp_alloc_next  = fin_alloc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            init_pass_reg   <= 1'b0;
            resp_status_reg <= bba_pkg::ST_OK;
            resp_alloc_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            init_pass_reg   <= init_pass_next;
            resp_status_reg <= resp_status_next;
            resp_alloc_reg  <= resp_alloc_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while still pending");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction accepted while busy");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load_out))
        else $error("out_valid raised without a result load");

endmodule

// ===== rtl/core/bitmap_block_allocator.sv =====
// bitmap_block_allocator: top level, joins control FSM, datapath and mark RAM.
// Depends on bba_pkg, bba_ctrl, bba_dp, bba_ram.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    req_type, size_bytes, offset_bytes
//   out      out_valid / out_ready  status, result_offset
//   cfg      cfg_we                 cfg_wdata (reserved_blocks)
//
// One transaction at a time; marks live in a 1024 x 2 RAM, one mark per cycle.
// Allocate: size check, span doubling, slot scan, head and fill marking.
// Free: range check, head read, walk over fill marks. Init: full sweep.
// After reset a clearing sweep over all marks runs with in_ready low.
// A pending result stalls only the hand-off; the input is taken when idle.
`timescale 1ns / 1ps

module bitmap_block_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bba_pkg::REQ_W-1:0]      req_type,
    input  logic [bba_pkg::SIZE_W-1:0]     size_bytes,
    input  logic [bba_pkg::OFF_W-1:0]      offset_bytes,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bba_pkg::STATUS_W-1:0]   status,
    output logic [bba_pkg::RES_W-1:0]      result_offset,
    input  logic                           cfg_we,
    input  logic [bba_pkg::CFG_W-1:0]      cfg_wdata
);

    bba_pkg::dp_cmd_t            cmd;
    bba_pkg::dp_sts_t            sts;
    logic                        ram_we;
    logic [bba_pkg::ADDR_W-1:0]  ram_waddr;
    logic [1:0]                  ram_wdata;
    logic [bba_pkg::ADDR_W-1:0]  ram_raddr;
    logic [1:0]                  ram_rdata;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bba_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .size_bytes    (size_bytes),
        .offset_bytes  (offset_bytes),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .status        (status),
        .result_offset (result_offset)
    );

    bba_ram #(
        .WIDTH (2),
        .DEPTH (bba_pkg::NUM_BLOCKS)
    ) u_marks (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== verif/bitmap_block_allocator_tb.sv =====
// bitmap_block_allocator_tb: self-checking bench for the bitmap block allocator.
// Depends on bba_pkg and bitmap_block_allocator; keeps its own copy of the block marks.
`timescale 1ns / 1ps

module bitmap_block_allocator_tb;

    localparam logic [bba_pkg::REQ_W-1:0] REQ_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int NUM_PHASES     = 7;
    localparam int PHASE_ITEMS    = 70;

    typedef struct {
        bba_pkg::status_t           st;
        logic [bba_pkg::RES_W-1:0]  res;
    } alloc_reply_t;

    typedef struct {
        logic [bba_pkg::REQ_W-1:0]  req;
        logic [bba_pkg::SIZE_W-1:0] size;
        logic [bba_pkg::OFF_W-1:0]  off;
        bit                         typed;
        bba_pkg::status_t           st;
        logic [bba_pkg::RES_W-1:0]  res;
    } stim_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [bba_pkg::REQ_W-1:0]    req_type = '0;
    logic [bba_pkg::SIZE_W-1:0]   size_bytes = '0;
    logic [bba_pkg::OFF_W-1:0]    offset_bytes = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [bba_pkg::STATUS_W-1:0] status;
    logic [bba_pkg::RES_W-1:0]    result_offset;
    logic                         cfg_we = 1'b0;
    logic [bba_pkg::CFG_W-1:0]    cfg_wdata = '0;

    bba_pkg::mark_t               heap_marks [bba_pkg::NUM_BLOCKS];
    logic [bba_pkg::CFG_W-1:0]    reserved_count;
    alloc_reply_t                 expected_replies [$];
    logic [bba_pkg::RES_W-1:0]    live_offsets [$];
    stim_row_t                    dir_rows [$];
    int                           err_count = 0;
    int                           stall_cycles = 0;
    bit                           no_idle = 1'b0;
    bit                           hold_rx = 1'b0;

    bitmap_block_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .size_bytes    (size_bytes),
        .offset_bytes  (offset_bytes),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .result_offset (result_offset),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // marks model: allocate, free, init
    function automatic void predict_request(input logic [bba_pkg::REQ_W-1:0] req,
                                            input logic [bba_pkg::SIZE_W-1:0] size,
                                            input logic [bba_pkg::OFF_W-1:0] off,
                                            output bba_pkg::status_t st,
                                            output logic [bba_pkg::RES_W-1:0] res);
        int unsigned level;
        int unsigned span;
        int unsigned slot;
        int unsigned k;
        int unsigned blk;
        int unsigned n;
        bit fits;
        bit found;
        st = bba_pkg::ST_OK;
        res = '0;
        case (req)
            bba_pkg::REQ_ALLOC:
            begin
                if (size > bba_pkg::HEAP_BYTES)
                    st = bba_pkg::ST_TOO_BIG;
                else
                begin
                    level = bba_pkg::BLOCK_BYTES;
                    while (level < size)
                        level = level * 2;
                    span = level / bba_pkg::BLOCK_BYTES;
                    slot = 0;
                    found = 1'b0;
                    while (!found && slot + span <= bba_pkg::NUM_BLOCKS)
                    begin
                        fits = 1'b1;
                        for (k = slot; k < slot + span; k++)
                            if (heap_marks[k] != bba_pkg::MARK_FREE)
                                fits = 1'b0;
                        if (fits)
                            found = 1'b1;
                        else
                            slot = slot + span;
                    end
                    if (found)
                    begin
                        heap_marks[slot] = bba_pkg::MARK_HEAD;
                        for (k = slot + 1; k < slot + span; k++)
                            heap_marks[k] = bba_pkg::MARK_FILL;
                        res = bba_pkg::RES_W'(slot * bba_pkg::BLOCK_BYTES);
                    end
                    else
                        st = bba_pkg::ST_FULL;
                end
            end
            bba_pkg::REQ_FREE:
            begin
                if (off >= bba_pkg::HEAP_BYTES)
                    st = bba_pkg::ST_OUTSIDE;
                else
                begin
                    blk = off / bba_pkg::BLOCK_BYTES;
                    if (heap_marks[blk] == bba_pkg::MARK_RSVD)
                        st = bba_pkg::ST_RESERVED;
                    else
                    begin
                        heap_marks[blk] = bba_pkg::MARK_FREE;
                        k = blk + 1;
                        while (k < bba_pkg::NUM_BLOCKS && heap_marks[k] == bba_pkg::MARK_FILL)
                        begin
                            heap_marks[k] = bba_pkg::MARK_FREE;
                            k++;
                        end
                    end
                end
            end
            bba_pkg::REQ_INIT:
            begin
                n = (reserved_count > bba_pkg::NUM_BLOCKS) ? bba_pkg::NUM_BLOCKS
                                                            : reserved_count;
                for (k = 0; k < bba_pkg::NUM_BLOCKS; k++)
                    heap_marks[k] = (k < n) ? bba_pkg::MARK_RSVD : bba_pkg::MARK_FREE;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void add_row(input logic [bba_pkg::REQ_W-1:0] req,
                                    input logic [bba_pkg::SIZE_W-1:0] size,
                                    input logic [bba_pkg::OFF_W-1:0] off, input bit typed,
                                    input bba_pkg::status_t st,
                                    input logic [bba_pkg::RES_W-1:0] res);
        stim_row_t row;
        row.req = req;
        row.size = size;
        row.off = off;
        row.typed = typed;
        row.st = st;
        row.res = res;
        dir_rows.push_back(row);
    endfunction

    task automatic send_item(input logic [bba_pkg::REQ_W-1:0] req,
                             input logic [bba_pkg::SIZE_W-1:0] size,
                             input logic [bba_pkg::OFF_W-1:0] off, input bit typed,
                             input bba_pkg::status_t tst,
                             input logic [bba_pkg::RES_W-1:0] tres);
        int gap;
        int idx;
        alloc_reply_t pred;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        size_bytes <= size;
        offset_bytes <= off;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(req, size, off, pred.st, pred.res);
        if (req == bba_pkg::REQ_ALLOC && pred.st == bba_pkg::ST_OK)
            live_offsets.push_back(pred.res);
        else if (req == bba_pkg::REQ_INIT)
            live_offsets.delete();
        else if (req == bba_pkg::REQ_FREE && pred.st == bba_pkg::ST_OK)
        begin
            for (idx = live_offsets.size() - 1; idx >= 0; idx--)
                if (live_offsets[idx] / bba_pkg::BLOCK_BYTES == off / bba_pkg::BLOCK_BYTES)
                    live_offsets.delete(idx);
        end
        if (typed)
        begin
            pred.st = tst;
            pred.res = tres;
        end
        expected_replies.push_back(pred);
    endtask

    task automatic send_random_item();
        int pick;
        int band;
        int idx;
        logic [bba_pkg::REQ_W-1:0]  req;
        logic [bba_pkg::SIZE_W-1:0] size;
        logic [bba_pkg::OFF_W-1:0]  off;
        pick = $urandom_range(0, 99);
        size = bba_pkg::SIZE_W'($urandom);
        off = bba_pkg::OFF_W'($urandom);
        if (pick < 48)
        begin
            req = bba_pkg::REQ_ALLOC;
            band = $urandom_range(0, 99);
            if (band < 70)
                size = bba_pkg::SIZE_W'($urandom_range(0, 64));
            else if (band < 90)
                size = bba_pkg::SIZE_W'($urandom_range(65, 1024));
            else if (band < 98)
                size = bba_pkg::SIZE_W'($urandom_range(1025, bba_pkg::HEAP_BYTES));
        end
        else if (pick < 88)
        begin
            req = bba_pkg::REQ_FREE;
            if (live_offsets.size() != 0 && $urandom_range(0, 99) < 85)
            begin
                idx = $urandom_range(0, live_offsets.size() - 1);
                off = bba_pkg::OFF_W'(live_offsets[idx] +
                                      $urandom_range(0, bba_pkg::BLOCK_BYTES - 1));
            end
        end
        else if (pick < 94)
            req = bba_pkg::REQ_INIT;
        else
            req = REQ_NOP;
        send_item(req, size, off, 1'b0, bba_pkg::ST_OK, '0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reserved(input logic [bba_pkg::CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        reserved_count = value;
        cfg_we <= 1'b0;
    endtask

    // result side: random ready gaps, one long hold on request, field checks
    initial
    begin
        int gap;
        alloc_reply_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_rx)
            begin
                hold_rx = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (expected_replies.size() == 0)
                report_mismatch($sformatf("result with nothing expected: status %0d offset %0d",
                                          status, result_offset));
            else
            begin
                want = expected_replies.pop_front();
                if (status !== want.st)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
                if (result_offset !== want.res)
                    report_mismatch($sformatf("result_offset %0d, expected %0d",
                                              result_offset, want.res));
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if ((in_valid && in_ready) || (out_valid && out_ready))
                    stall_cycles = 0;
                else
                    stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int phase;
        int item;
        int row;
        logic [bba_pkg::CFG_W-1:0] cfg_vals [NUM_PHASES];
        foreach (heap_marks[i])
            heap_marks[i] = bba_pkg::MARK_FREE;
        reserved_count = '0;

        // heap empty after reset; init only later picks up the reserved count
        add_row(bba_pkg::REQ_ALLOC, 16'd16384, 16'd0,     1'b1, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_FREE,  16'd0,     16'd0,     1'b1, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_ALLOC, 16'd0,     16'hFFFF,  1'b1, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_ALLOC, 16'd16,    16'd0,     1'b1, bba_pkg::ST_OK,       14'd16);
        add_row(bba_pkg::REQ_ALLOC, 16'd17,    16'd0,     1'b1, bba_pkg::ST_OK,       14'd32);
        add_row(bba_pkg::REQ_ALLOC, 16'hFFFF,  16'd0,     1'b1, bba_pkg::ST_TOO_BIG,  14'd0);
        add_row(bba_pkg::REQ_ALLOC, 16'd16385, 16'd0,     1'b1, bba_pkg::ST_TOO_BIG,  14'd0);
        add_row(bba_pkg::REQ_FREE,  16'hFFFF,  16'hFFFF,  1'b1, bba_pkg::ST_OUTSIDE,  14'd0);
        add_row(bba_pkg::REQ_FREE,  16'd0,     16'd16384, 1'b1, bba_pkg::ST_OUTSIDE,  14'd0);
        add_row(bba_pkg::REQ_FREE,  16'd0,     16'd32,    1'b0, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_FREE,  16'd0,     16'd16383, 1'b1, bba_pkg::ST_OK,       14'd0);
        add_row(REQ_NOP,            16'hFFFF,  16'hFFFF,  1'b1, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_INIT,  16'd0,     16'd0,     1'b1, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_FREE,  16'd0,     16'd0,     1'b1, bba_pkg::ST_RESERVED, 14'd0);
        add_row(bba_pkg::REQ_FREE,  16'd0,     16'd63,    1'b1, bba_pkg::ST_RESERVED, 14'd0);
        add_row(bba_pkg::REQ_ALLOC, 16'd16384, 16'd0,     1'b1, bba_pkg::ST_FULL,     14'd0);
        add_row(bba_pkg::REQ_ALLOC, 16'd64,    16'd0,     1'b0, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_FREE,  16'd0,     16'd72,    1'b0, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_ALLOC, 16'd8192,  16'd0,     1'b0, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_ALLOC, 16'd8192,  16'd0,     1'b0, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_ALLOC, 16'd16,    16'd0,     1'b0, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_FREE,  16'd0,     16'd8208,  1'b0, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_FREE,  16'd0,     16'd8192,  1'b0, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_ALLOC, 16'd16383, 16'd0,     1'b0, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_INIT,  16'd0,     16'd0,     1'b0, bba_pkg::ST_OK,       14'd0);
        add_row(bba_pkg::REQ_ALLOC, 16'd16,    16'd0,     1'b0, bba_pkg::ST_OK,       14'd0);

        cfg_vals[0] = 11'd0;
        cfg_vals[1] = 11'd2047;
        cfg_vals[2] = 11'd1;
        cfg_vals[3] = 11'd1024;
        cfg_vals[4] = 11'd1023;
        cfg_vals[5] = bba_pkg::CFG_W'($urandom_range(0, 63));
        cfg_vals[6] = bba_pkg::CFG_W'($urandom_range(0, 2047));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_reserved(11'd4);
        for (row = 0; row < dir_rows.size(); row++)
            send_item(dir_rows[row].req, dir_rows[row].size, dir_rows[row].off,
                      dir_rows[row].typed, dir_rows[row].st, dir_rows[row].res);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained();
            write_reserved(cfg_vals[phase]);
            no_idle = (phase == 4);
            send_item(bba_pkg::REQ_INIT, bba_pkg::SIZE_W'($urandom),
                      bba_pkg::OFF_W'($urandom), 1'b0, bba_pkg::ST_OK, '0);
            for (item = 0; item < PHASE_ITEMS; item++)
            begin
                // long receiver hold-off while transactions keep coming
                if (phase == 2 && item == 5)
                    hold_rx = 1'b1;
                send_random_item();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_replies.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
